[sv/tkf_pkg.sv]
`timescale 1ns / 1ps
package tkf_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int CORDIC_N     = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int ROOT_STEPS   = 32;
    localparam int DIV_W        = 32 + FRAC_BITS;
    localparam int CNT_MAX      = (DIV_W > ROOT_STEPS) ? DIV_W : ROOT_STEPS;
    localparam int CNT_W        = $clog2(CNT_MAX);
    localparam int CX_W         = 52;
    localparam int CFG_IDX_W    = 3;

    localparam logic signed [31:0] HALF_PI_Q30     = 32'sd1686629713;
    localparam logic signed [31:0] DEG_PER_RAD_Q24 = 32'sd961263669;
    localparam logic signed [63:0] ONE_Q           = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] MAX32           = 64'sd2147483647;
    localparam logic signed [63:0] MIN32           = -64'sd2147483648;

    localparam logic signed [31:0] RST_A  = 32'sd65536;
    localparam logic signed [31:0] RST_B  = 32'sd3277;
    localparam logic signed [31:0] RST_H  = 32'sd65536;
    localparam logic [30:0]        RST_Q  = 31'd2621;
    localparam logic [30:0]        RST_R  = 31'd589824;
    localparam logic [30:0]        RST_P0 = 31'd262144;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEG = 3'd0,
        CFG_A   = 3'd1,
        CFG_B   = 3'd2,
        CFG_H   = 3'd3,
        CFG_Q   = 3'd4,
        CFG_R   = 3'd5,
        CFG_P0  = 3'd6
    } t_cfg_idx;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SQ0, ST_SQ1, ST_SQ2, ST_SQ3, ST_ROOT_LD, ST_ROOT,
        ST_COR_LD, ST_COR, ST_COR_FIX, ST_ANG_MUL, ST_ANG_WB,
        ST_K0, ST_K1, ST_K2, ST_K3, ST_K4, ST_K5, ST_K6, ST_K7, ST_K8, ST_K9,
        ST_K10, ST_DIV, ST_K11, ST_K12, ST_K13, ST_K14, ST_K15, ST_K16, ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        MS_NONE, MS_AZ2, MS_AX2, MS_AY2, MS_DEG, MS_A_EST, MS_B_U, MS_A_COV,
        MS_T_A, MS_H_MP, MS_MP_H, MS_T_H, MS_K_INN, MS_K_H, MS_T_MP
    } t_mul_sel;

    typedef enum logic [3:0] {
        WB_NONE, WB_AZ2, WB_SUMR, WB_SUMP, WB_ANG, WB_BX, WB_XP, WB_T_SAT,
        WB_MP, WB_PH, WB_S, WB_INNOV, WB_K, WB_EST, WB_T_ONE, WB_COV
    } t_wb_sel;

    typedef struct packed {
        t_mul_sel mul_sel;
        t_wb_sel  wb_sel;
        logic     ch;
        logic     in_load;
        logic     sq_load;
        logic     sq_step;
        logic     cor_load;
        logic     cor_step;
        logic     cor_fix;
        logic     div_load;
        logic     div_step;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic sq_last;
        logic cor_last;
        logic div_last;
    } t_stat;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > MAX32) r = MAX32[31:0];
        else if (v < MIN32) r = MIN32[31:0];
        else r = v[31:0];
        return r;
    endfunction

    // floor((v + 2^(s-1)) / 2^s)
    function automatic logic signed [63:0] rshift(input logic signed [63:0] v, input int s);
        logic signed [63:0] bias;
        bias = 64'sd1 <<< (s - 1);
        return (v + bias) >>> s;
    endfunction

    function automatic logic signed [31:0] atan_entry(input logic [4:0] i);
        logic signed [31:0] r;
        case (i)
            5'd0:  r = 32'h3243F6A8;
            5'd1:  r = 32'h1DAC6705;
            5'd2:  r = 32'h0FADBAFC;
            5'd3:  r = 32'h07F56EA6;
            5'd4:  r = 32'h03FEAB76;
            5'd5:  r = 32'h01FFD55B;
            5'd6:  r = 32'h00FFFAAA;
            5'd7:  r = 32'h007FFF55;
            5'd8:  r = 32'h003FFFEA;
            5'd9:  r = 32'h001FFFFD;
            5'd10: r = 32'h000FFFFF;
            5'd11: r = 32'h0007FFFF;
            5'd12: r = 32'h0003FFFF;
            5'd13: r = 32'h0001FFFF;
            5'd14: r = 32'h0000FFFF;
            5'd15: r = 32'h00007FFF;
            5'd16: r = 32'h00003FFF;
            5'd17: r = 32'h00001FFF;
            5'd18: r = 32'h00000FFF;
            5'd19: r = 32'h000007FF;
            5'd20: r = 32'h000003FF;
            5'd21: r = 32'h000001FF;
            5'd22: r = 32'h000000FF;
            5'd23: r = 32'h0000007F;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

endpackage

[sv/tkf_if.sv]
`timescale 1ns / 1ps
interface tkf_sample_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic signed [31:0] rate_x;
    logic signed [31:0] rate_y;

    modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, output ready);
endinterface

interface tkf_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] raw_roll;
    logic signed [31:0] raw_pitch;
    logic signed [31:0] filtered_roll;
    logic signed [31:0] filtered_pitch;

    modport source (output valid, raw_roll, raw_pitch, filtered_roll, filtered_pitch,
                    input ready);
    modport sink   (input valid, raw_roll, raw_pitch, filtered_roll, filtered_pitch,
                    output ready);
endinterface

[sv/tkf_ctrl.sv]
`timescale 1ns / 1ps
module tkf_ctrl
    import tkf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_ch, n_ch;
    logic   r_out_valid;
    logic   w_free;

    assign w_free      = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ch        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            if (o_cmd.out_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ch    = r_ch;
        unique case (r_state)
            ST_IDLE:    if (i_in_valid) n_state = ST_SQ0;
            ST_SQ0:     n_state = ST_SQ1;
            ST_SQ1:     n_state = ST_SQ2;
            ST_SQ2:     n_state = ST_SQ3;
            ST_SQ3:     n_state = ST_ROOT_LD;
            ST_ROOT_LD: n_state = ST_ROOT;
            ST_ROOT: begin
                if (i_stat.sq_last) begin
                    n_ch    = !r_ch;
                    n_state = r_ch ? ST_COR_LD : ST_ROOT_LD;
                end
            end
            ST_COR_LD:  n_state = ST_COR;
            ST_COR:     if (i_stat.cor_last) n_state = ST_COR_FIX;
            ST_COR_FIX: n_state = ST_ANG_MUL;
            ST_ANG_MUL: n_state = ST_ANG_WB;
            ST_ANG_WB: begin
                n_ch    = !r_ch;
                n_state = r_ch ? ST_K0 : ST_COR_LD;
            end
            ST_K0:  n_state = ST_K1;
            ST_K1:  n_state = ST_K2;
            ST_K2:  n_state = ST_K3;
            ST_K3:  n_state = ST_K4;
            ST_K4:  n_state = ST_K5;
            ST_K5:  n_state = ST_K6;
            ST_K6:  n_state = ST_K7;
            ST_K7:  n_state = ST_K8;
            ST_K8:  n_state = ST_K9;
            ST_K9:  n_state = ST_K10;
            ST_K10: n_state = ST_DIV;
            ST_DIV: if (i_stat.div_last) n_state = ST_K11;
            ST_K11: n_state = ST_K12;
            ST_K12: n_state = ST_K13;
            ST_K13: n_state = ST_K14;
            ST_K14: n_state = ST_K15;
            ST_K15: n_state = ST_K16;
            ST_K16: begin
                n_ch    = !r_ch;
                n_state = r_ch ? ST_DONE : ST_K0;
            end
            ST_DONE: if (w_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = MS_NONE;
        o_cmd.wb_sel  = WB_NONE;
        o_cmd.ch      = r_ch;
        o_in_ready    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.in_load = i_in_valid;
            end
            ST_SQ0:     o_cmd.mul_sel = MS_AZ2;
            ST_SQ1: begin
                o_cmd.mul_sel = MS_AX2;
                o_cmd.wb_sel  = WB_AZ2;
            end
            ST_SQ2: begin
                o_cmd.mul_sel = MS_AY2;
                o_cmd.wb_sel  = WB_SUMR;
            end
            ST_SQ3:     o_cmd.wb_sel   = WB_SUMP;
            ST_ROOT_LD: o_cmd.sq_load  = 1'b1;
            ST_ROOT:    o_cmd.sq_step  = 1'b1;
            ST_COR_LD:  o_cmd.cor_load = 1'b1;
            ST_COR:     o_cmd.cor_step = 1'b1;
            ST_COR_FIX: o_cmd.cor_fix  = 1'b1;
            ST_ANG_MUL: o_cmd.mul_sel  = MS_DEG;
            ST_ANG_WB:  o_cmd.wb_sel   = WB_ANG;
            ST_K0:      o_cmd.mul_sel  = MS_A_EST;
            ST_K1: begin
                o_cmd.mul_sel = MS_B_U;
                o_cmd.wb_sel  = WB_BX;
            end
            ST_K2: begin
                o_cmd.mul_sel = MS_A_COV;
                o_cmd.wb_sel  = WB_XP;
            end
            ST_K3:      o_cmd.wb_sel  = WB_T_SAT;
            ST_K4:      o_cmd.mul_sel = MS_T_A;
            ST_K5:      o_cmd.wb_sel  = WB_MP;
            ST_K6:      o_cmd.mul_sel = MS_H_MP;
            ST_K7: begin
                o_cmd.mul_sel = MS_MP_H;
                o_cmd.wb_sel  = WB_T_SAT;
            end
            ST_K8: begin
                o_cmd.mul_sel = MS_T_H;
                o_cmd.wb_sel  = WB_PH;
            end
            ST_K9:      o_cmd.wb_sel = WB_S;
            ST_K10: begin
                o_cmd.div_load = 1'b1;
                o_cmd.wb_sel   = WB_INNOV;
            end
            ST_DIV:     o_cmd.div_step = 1'b1;
            ST_K11:     o_cmd.wb_sel   = WB_K;
            ST_K12:     o_cmd.mul_sel  = MS_K_INN;
            ST_K13: begin
                o_cmd.mul_sel = MS_K_H;
                o_cmd.wb_sel  = WB_EST;
            end
            ST_K14:     o_cmd.wb_sel  = WB_T_ONE;
            ST_K15:     o_cmd.mul_sel = MS_T_MP;
            ST_K16:     o_cmd.wb_sel  = WB_COV;
            ST_DONE:    o_cmd.out_load = w_free;
            default: ;
        endcase
    end

endmodule

[sv/tkf_datapath.sv]
`timescale 1ns / 1ps
module tkf_datapath
    import tkf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic signed [31:0]   i_accel_x,
    input  logic signed [31:0]   i_accel_y,
    input  logic signed [31:0]   i_accel_z,
    input  logic signed [31:0]   i_rate_x,
    input  logic signed [31:0]   i_rate_y,
    output logic signed [31:0]   o_raw_roll,
    output logic signed [31:0]   o_raw_pitch,
    output logic signed [31:0]   o_filtered_roll,
    output logic signed [31:0]   o_filtered_pitch
);

    // configuration
    logic               r_deg;
    logic signed [31:0] r_a, r_b, r_h;
    logic [30:0]        r_q, r_r;

    // filter state
    logic signed [31:0] r_est_r, r_est_p, r_cov_r, r_cov_p;

    // sample and working registers
    logic signed [31:0] r_ax, r_ay, r_az, r_gx, r_gy;
    logic [63:0]        r_az2, r_sum_r, r_sum_p;
    logic [63:0]        r_sq_v;
    logic [35:0]        r_sq_rem;
    logic [31:0]        r_sq_root;
    logic [31:0]        r_den_r, r_den_p;
    logic signed [CX_W-1:0] r_cx, r_cy;
    logic signed [31:0] r_cz;
    logic signed [31:0] r_raw_r, r_raw_p;
    logic signed [63:0] r_prod, r_bx;
    logic signed [31:0] r_xp, r_t, r_mp, r_ph, r_s, r_k;
    logic [DIV_W-1:0]   r_dq;
    logic [31:0]        r_drem, r_dd;
    logic               r_dneg;
    logic [CNT_W-1:0]   r_cnt;
    logic signed [31:0] r_o_rr, r_o_rp, r_o_fr, r_o_fp;

    // channel views
    logic signed [31:0] w_est, w_cov, w_u, w_y, w_num;
    logic [31:0]        w_den;
    assign w_est = i_cmd.ch ? r_est_p : r_est_r;
    assign w_cov = i_cmd.ch ? r_cov_p : r_cov_r;
    assign w_u   = i_cmd.ch ? r_gy    : r_gx;
    assign w_y   = i_cmd.ch ? r_raw_p : r_raw_r;
    assign w_num = i_cmd.ch ? r_ax    : r_ay;
    assign w_den = i_cmd.ch ? r_den_p : r_den_r;

    // shared multiplier
    logic signed [31:0] w_ma, w_mb;
    logic signed [63:0] w_prod, w_mq;
    always_comb begin
        case (i_cmd.mul_sel)
            MS_AZ2:   begin w_ma = r_az;  w_mb = r_az;            end
            MS_AX2:   begin w_ma = r_ax;  w_mb = r_ax;            end
            MS_AY2:   begin w_ma = r_ay;  w_mb = r_ay;            end
            MS_DEG:   begin w_ma = r_cz;  w_mb = DEG_PER_RAD_Q24; end
            MS_A_EST: begin w_ma = r_a;   w_mb = w_est;           end
            MS_B_U:   begin w_ma = r_b;   w_mb = w_u;             end
            MS_A_COV: begin w_ma = r_a;   w_mb = w_cov;           end
            MS_T_A:   begin w_ma = r_t;   w_mb = r_a;             end
            MS_H_MP:  begin w_ma = r_h;   w_mb = r_mp;            end
            MS_MP_H:  begin w_ma = r_mp;  w_mb = r_h;             end
            MS_T_H:   begin w_ma = r_t;   w_mb = r_h;             end
            MS_K_INN: begin w_ma = r_k;   w_mb = r_t;             end
            MS_K_H:   begin w_ma = r_k;   w_mb = r_h;             end
            MS_T_MP:  begin w_ma = r_t;   w_mb = r_mp;            end
            default:  begin w_ma = '0;    w_mb = '0;              end
        endcase
    end
    assign w_prod = w_ma * w_mb;
    assign w_mq   = rshift(r_prod, FRAC_BITS);

    // accelerometer angle to output format
    logic signed [31:0] w_ang, w_ang_out;
    assign w_ang     = r_deg ? sat32(rshift(r_prod, 54 - FRAC_BITS))
                             : sat32(rshift(64'(r_cz), 30 - FRAC_BITS));
    assign w_ang_out = i_cmd.ch ? sat32(-64'(w_ang)) : w_ang;

    // square root, two bits per step
    logic [35:0] w_sq_tr, w_sq_t;
    logic        w_sq_ge;
    logic [31:0] w_sq_root;
    assign w_sq_tr   = {r_sq_rem[33:0], r_sq_v[63:62]};
    assign w_sq_t    = {2'b00, r_sq_root, 2'b01};
    assign w_sq_ge   = w_sq_tr >= w_sq_t;
    assign w_sq_root = {r_sq_root[30:0], w_sq_ge};

    // vectoring CORDIC step
    logic signed [CX_W-1:0] w_dx, w_dy;
    logic signed [31:0]     w_atan, w_zfix;
    assign w_dx   = r_cy >>> r_cnt;
    assign w_dy   = r_cx >>> r_cnt;
    assign w_atan = atan_entry(r_cnt[4:0]);
    always_comb begin
        if (w_num == 32'sd0) w_zfix = 32'sd0;
        else if (w_den == 32'd0) w_zfix = w_num[31] ? -HALF_PI_Q30 : HALF_PI_Q30;
        else w_zfix = r_cz;
    end

    // restoring divider on magnitudes
    logic signed [DIV_W-1:0] w_dnum;
    logic [DIV_W-1:0]        w_dmag;
    logic [31:0]             w_sabs;
    logic [32:0]             w_dsh, w_dsub;
    logic                    w_dge;
    logic signed [63:0]      w_qmag, w_kval;
    assign w_dnum = {r_ph, {FRAC_BITS{1'b0}}};
    assign w_dmag = r_ph[31] ? DIV_W'(-w_dnum) : DIV_W'(w_dnum);
    assign w_sabs = r_s[31] ? (~r_s + 32'd1) : r_s;
    assign w_dsh  = {r_drem, r_dq[DIV_W-1]};
    assign w_dsub = w_dsh - {1'b0, r_dd};
    assign w_dge  = w_dsh >= {1'b0, r_dd};
    assign w_qmag = $signed({{(64 - DIV_W){1'b0}}, r_dq});
    assign w_kval = r_dneg ? -w_qmag : w_qmag;

    assign o_stat.sq_last  = r_cnt == CNT_W'(ROOT_STEPS - 1);
    assign o_stat.cor_last = r_cnt == CNT_W'(CORDIC_N - 1);
    assign o_stat.div_last = r_cnt == CNT_W'(DIV_W - 1);

    // configuration and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg   <= 1'b1;
            r_a     <= RST_A;
            r_b     <= RST_B;
            r_h     <= RST_H;
            r_q     <= RST_Q;
            r_r     <= RST_R;
            r_est_r <= '0;
            r_est_p <= '0;
            r_cov_r <= $signed({1'b0, RST_P0});
            r_cov_p <= $signed({1'b0, RST_P0});
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_DEG: r_deg <= i_cfg_data[0];
                    CFG_A:   r_a   <= i_cfg_data;
                    CFG_B:   r_b   <= i_cfg_data;
                    CFG_H:   r_h   <= i_cfg_data;
                    CFG_Q:   r_q   <= i_cfg_data[30:0];
                    CFG_R:   r_r   <= i_cfg_data[30:0];
                    CFG_P0: begin
                        r_cov_r <= $signed({1'b0, i_cfg_data[30:0]});
                        r_cov_p <= $signed({1'b0, i_cfg_data[30:0]});
                    end
                    default: ;
                endcase
            end
            if (i_cmd.wb_sel == WB_EST) begin
                if (i_cmd.ch) r_est_p <= sat32(64'(r_xp) + w_mq);
                else          r_est_r <= sat32(64'(r_xp) + w_mq);
            end
            if (i_cmd.wb_sel == WB_COV) begin
                if (i_cmd.ch) r_cov_p <= sat32(w_mq);
                else          r_cov_r <= sat32(w_mq);
            end
        end
    end

    // working datapath
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;

        if (i_cmd.in_load) begin
            r_ax <= i_accel_x;
            r_ay <= i_accel_y;
            r_az <= i_accel_z;
            r_gx <= i_rate_x;
            r_gy <= i_rate_y;
        end

        case (i_cmd.wb_sel)
            WB_AZ2:   r_az2   <= 64'(r_prod);
            WB_SUMR:  r_sum_r <= r_az2 + 64'(r_prod);
            WB_SUMP:  r_sum_p <= r_az2 + 64'(r_prod);
            WB_ANG: begin
                if (i_cmd.ch) r_raw_p <= w_ang_out;
                else          r_raw_r <= w_ang_out;
            end
            WB_BX:    r_bx <= w_mq;
            WB_XP:    r_xp <= sat32(r_bx + w_mq);
            WB_T_SAT: r_t  <= sat32(w_mq);
            WB_MP:    r_mp <= sat32(64'(sat32(w_mq)) + 64'({1'b0, r_q}));
            WB_PH:    r_ph <= sat32(w_mq);
            WB_S:     r_s  <= sat32(w_mq + 64'({1'b0, r_r}));
            WB_INNOV: r_t  <= sat32(64'(w_y) - 64'(r_xp));
            WB_K:     r_k  <= (r_s == 32'sd0) ? 32'sd0 : sat32(w_kval);
            WB_T_ONE: r_t  <= sat32(ONE_Q - w_mq);
            default: ;
        endcase

        if (i_cmd.sq_load || i_cmd.cor_load || i_cmd.div_load) r_cnt <= '0;
        else if (i_cmd.sq_step || i_cmd.cor_step || i_cmd.div_step) r_cnt <= r_cnt + 1'b1;

        if (i_cmd.sq_load) begin
            r_sq_v    <= i_cmd.ch ? r_sum_p : r_sum_r;
            r_sq_rem  <= '0;
            r_sq_root <= '0;
        end else if (i_cmd.sq_step) begin
            r_sq_v    <= {r_sq_v[61:0], 2'b00};
            r_sq_rem  <= w_sq_ge ? (w_sq_tr - w_sq_t) : w_sq_tr;
            r_sq_root <= w_sq_root;
            if (o_stat.sq_last) begin
                if (i_cmd.ch) r_den_p <= w_sq_root;
                else          r_den_r <= w_sq_root;
            end
        end

        if (i_cmd.cor_load) begin
            r_cx <= $signed({{(CX_W - 48){1'b0}}, w_den, 16'h0000});
            r_cy <= $signed({{(CX_W - 48){w_num[31]}}, w_num, 16'h0000});
            r_cz <= '0;
        end else if (i_cmd.cor_step) begin
            if (!r_cy[CX_W-1]) begin
                r_cx <= r_cx + w_dx;
                r_cy <= r_cy - w_dy;
                r_cz <= r_cz + w_atan;
            end else begin
                r_cx <= r_cx - w_dx;
                r_cy <= r_cy + w_dy;
                r_cz <= r_cz - w_atan;
            end
        end else if (i_cmd.cor_fix) begin
            r_cz <= w_zfix;
        end

        if (i_cmd.div_load) begin
            r_dq   <= w_dmag;
            r_dd   <= w_sabs;
            r_drem <= '0;
            r_dneg <= r_ph[31] ^ r_s[31];
        end else if (i_cmd.div_step) begin
            r_drem <= w_dge ? w_dsub[31:0] : w_dsh[31:0];
            r_dq   <= {r_dq[DIV_W-2:0], w_dge};
        end

        if (i_cmd.out_load) begin
            r_o_rr <= r_raw_r;
            r_o_rp <= r_raw_p;
            r_o_fr <= r_est_r;
            r_o_fp <= r_est_p;
        end
    end

    assign o_raw_roll       = r_o_rr;
    assign o_raw_pitch      = r_o_rp;
    assign o_filtered_roll  = r_o_fr;
    assign o_filtered_pitch = r_o_fp;

endmodule

[sv/tilt_kalman_fusion.sv]
`timescale 1ns / 1ps
// Tilt estimator: accelerometer roll/pitch fused with gyro rates by two scalar
// Kalman filters.
// i_sample (valid/ready) carries one calibrated sample: accel_x/y/z, rate_x/y,
// all Q16.16. o_result (valid/ready) returns one transaction per sample:
// raw_roll, raw_pitch from the accelerometer and the filtered estimates.
// Registers are written through i_cfg_we / i_cfg_index / i_cfg_data; the user
// must write them only while idle, which the block does not enforce. Writing
// start_covariance also reloads both covariances. One sample is in flight at
// a time. The work runs through the shared 32x32 multiplier sequence, the
// two-bit-per-cycle square root (32 steps per channel) and the bit-serial
// gain divider (32 + FRAC_BITS steps per channel).
// A finished result waits in the output register; the next sample is taken
// meanwhile, and the block holds in its final state only if the receiver
// still stalls the previous result when the new one is done.
// Synchronous reset clears both estimates, loads the reset covariance and the
// reset register values, and drops any pending result.
module tilt_kalman_fusion
    import tkf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    tkf_sample_if.sink           i_sample,
    tkf_result_if.source         o_result
);

    t_cmd  w_cmd;
    t_stat w_stat;

    tkf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_sample.valid),
        .o_in_ready  (i_sample.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    tkf_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_accel_x        (i_sample.accel_x),
        .i_accel_y        (i_sample.accel_y),
        .i_accel_z        (i_sample.accel_z),
        .i_rate_x         (i_sample.rate_x),
        .i_rate_y         (i_sample.rate_y),
        .o_raw_roll       (o_result.raw_roll),
        .o_raw_pitch      (o_result.raw_pitch),
        .o_filtered_roll  (o_result.filtered_roll),
        .o_filtered_pitch (o_result.filtered_pitch)
    );

endmodule

[sv/tkf_checker.sv]
`timescale 1ns / 1ps
module tkf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_raw_roll,
    input logic [31:0] i_filtered_pitch
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_raw_roll) && $stable(i_filtered_pitch))
        else $error("result payload changed while stalled");

    // one sample in flight: input closes right after a transaction
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("sample taken while another is in work");

    // a result never appears right after a sample is taken
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result appeared one cycle after a sample");

endmodule

bind tilt_kalman_fusion tkf_checker u_tkf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_sample.valid),
    .i_in_ready       (i_sample.ready),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_raw_roll       (o_result.raw_roll),
    .i_filtered_pitch (o_result.filtered_pitch)
);

[tb/tilt_kalman_fusion_test.sv]
`timescale 1ns / 1ps
module tilt_kalman_fusion_test;
    import tkf_pkg::*;

    typedef logic signed [63:0] s64;
    typedef logic signed [31:0] s32;

    typedef struct {
        s32 ax, ay, az, gx, gy;
    } t_imu;

    typedef struct {
        s32 raw_roll, raw_pitch, filt_roll, filt_pitch;
    } t_tilt;

    typedef struct {
        t_imu  imu;
        bit    typed;
        t_tilt tilt;
    } t_row;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam s64 HALF_PI = 64'sd1686629713;
    localparam s64 DEG_Q24 = 64'sd961263669;
    localparam s32 S_MAX   = 32'sh7FFFFFFF;
    localparam s32 S_MIN   = 32'sh80000000;
    localparam s32 ONE_G   = 32'sd65536;
    localparam int LATENCY = 250;

    localparam s64 ATAN_TAB [24] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    tkf_sample_if sample_if ();
    tkf_result_if result_if ();

    tilt_kalman_fusion u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_sample    (sample_if),
        .o_result    (result_if)
    );

    // shadow registers and filter state
    bit   use_degrees;
    s64   gain_a, gain_b, gain_h, noise_q, noise_r, cov_start;
    s64   roll_est, roll_cov, pitch_est, pitch_cov;

    t_tilt tilt_q[$];
    bit    failed = 1'b0;
    int    tx_idle_pct = 0;
    int    rx_stall_pct = 0;

    initial forever #4 i_clk = ~i_clk;

    initial begin
        sample_if.valid = 1'b0;
        sample_if.accel_x = '0;
        sample_if.accel_y = '0;
        sample_if.accel_z = '0;
        sample_if.rate_x = '0;
        sample_if.rate_y = '0;
        result_if.ready = 1'b0;
    end

    function automatic s64 clamp32(s64 v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic s64 round_sh(s64 v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic s64 qmul(s64 a, s64 b);
        return round_sh(a * b, FRAC_BITS);
    endfunction

    function automatic s64 floor_root(logic [63:0] v);
        logic [63:0] res, b;
        res = '0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return s64'(res);
    endfunction

    function automatic logic [63:0] sq_mag(s64 a);
        logic [63:0] m;
        m = (a < 0) ? $unsigned(-a) : $unsigned(a);
        return m * m;
    endfunction

    // vectoring rotation, result in Q30 radians; den is never negative
    function automatic s64 arctan_q30(s64 num, s64 den);
        s64 x, y, z, dx, dy;
        z = 0;
        if (num == 0) return 0;
        if (den == 0) return (num > 0) ? HALF_PI : -HALF_PI;
        x = den * 64'sd65536;
        y = num * 64'sd65536;
        for (int i = 0; i < CORDIC_N; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx; y = y - dy; z = z + ATAN_TAB[i];
            end else begin
                x = x - dx; y = y + dy; z = z - ATAN_TAB[i];
            end
        end
        return z;
    endfunction

    function automatic s64 scale_angle(s64 z);
        if (use_degrees) return clamp32(round_sh(z * DEG_Q24, 54 - FRAC_BITS));
        return clamp32(round_sh(z, 30 - FRAC_BITS));
    endfunction

    task automatic kalman_update(inout s64 est, inout s64 cov, input s64 u, input s64 y);
        s64 xp, mp, s, ph, k, innov;
        xp = clamp32(qmul(gain_a, est) + qmul(gain_b, u));
        mp = clamp32(clamp32(qmul(clamp32(qmul(gain_a, cov)), gain_a)) + noise_q);
        s = clamp32(qmul(clamp32(qmul(gain_h, mp)), gain_h) + noise_r);
        ph = clamp32(qmul(mp, gain_h));
        k = (s == 0) ? 64'sd0 : clamp32((ph * (64'sd1 <<< FRAC_BITS)) / s);
        innov = clamp32(y - xp);
        est = clamp32(xp + qmul(k, innov));
        cov = clamp32(qmul(clamp32((64'sd1 <<< FRAC_BITS) - qmul(k, gain_h)), mp));
    endtask

    task automatic predict_tilt(input t_imu m, output t_tilt t);
        s64 ax, ay, az, roll, pitch;
        ax = m.ax; ay = m.ay; az = m.az;
        roll = scale_angle(arctan_q30(ay, floor_root(sq_mag(ax) + sq_mag(az))));
        pitch = clamp32(-scale_angle(arctan_q30(ax, floor_root(sq_mag(ay) + sq_mag(az)))));
        kalman_update(roll_est, roll_cov, s64'(m.gx), roll);
        kalman_update(pitch_est, pitch_cov, s64'(m.gy), pitch);
        t.raw_roll = roll[31:0];
        t.raw_pitch = pitch[31:0];
        t.filt_roll = roll_est[31:0];
        t.filt_pitch = pitch_est[31:0];
    endtask

    task automatic restore_defaults();
        use_degrees = 1'b1;
        gain_a = 65536;
        gain_b = 3277;
        gain_h = 65536;
        noise_q = 2621;
        noise_r = 589824;
        cov_start = 262144;
        roll_est = 0;
        pitch_est = 0;
        roll_cov = cov_start;
        pitch_cov = cov_start;
    endtask

    // caller lowers cfg_we after the last write of a batch
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_DEG: use_degrees = val[0];
            CFG_A:   gain_a = s64'(s32'(val));
            CFG_B:   gain_b = s64'(s32'(val));
            CFG_H:   gain_h = s64'(s32'(val));
            CFG_Q:   noise_q = s64'({33'd0, val[30:0]});
            CFG_R:   noise_r = s64'({33'd0, val[30:0]});
            CFG_P0: begin
                cov_start = s64'({33'd0, val[30:0]});
                roll_cov = cov_start;
                pitch_cov = cov_start;
            end
            default: ;
        endcase
    endtask

    task automatic send_sample(input t_imu m, input bit typed, input t_tilt tv);
        t_tilt t;
        sample_if.valid <= 1'b1;
        sample_if.accel_x <= m.ax;
        sample_if.accel_y <= m.ay;
        sample_if.accel_z <= m.az;
        sample_if.rate_x <= m.gx;
        sample_if.rate_y <= m.gy;
        @(posedge i_clk);
        while (!sample_if.ready) @(posedge i_clk);
        predict_tilt(m, t);
        tilt_q.push_back(typed ? tv : t);
        while ($urandom_range(99) < tx_idle_pct) begin
            sample_if.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    function automatic t_imu random_imu();
        t_imu m;
        m.ax = $urandom; m.ay = $urandom; m.az = $urandom;
        m.gx = $urandom; m.gy = $urandom;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: begin
                // plausible motion: near one g, modest rates
                m.ax = int'($urandom_range(131072)) - 65536;
                m.ay = int'($urandom_range(131072)) - 65536;
                m.az = int'($urandom_range(131072)) - 65536 + (($urandom_range(1) != 0) ? ONE_G : -ONE_G);
                m.gx = int'($urandom_range(2097152)) - 1048576;
                m.gy = int'($urandom_range(2097152)) - 1048576;
            end
            6: begin
                if ($urandom_range(1) != 0) m.ax = '0;
                if ($urandom_range(1) != 0) m.ay = '0;
                if ($urandom_range(1) != 0) m.az = '0;
            end
            7: begin
                m.ax = ($urandom_range(1) != 0) ? S_MAX : S_MIN;
                m.ay = ($urandom_range(1) != 0) ? S_MAX : S_MIN;
                m.az = ($urandom_range(2) == 0) ? 32'sd0 : m.az;
                m.gx = ($urandom_range(1) != 0) ? S_MAX : S_MIN;
            end
            default: ;
        endcase
        return m;
    endfunction

    task automatic apply_setting(input int k);
        logic [31:0] r;
        case (k % 5)
            0: begin
                write_reg(CFG_DEG, 32'd0);
                write_reg(CFG_A, 32'd65536);
                write_reg(CFG_B, $urandom_range(65536));
                write_reg(CFG_H, 32'd65536);
                write_reg(CFG_Q, 32'd2621);
                write_reg(CFG_R, 32'd589824);
                write_reg(CFG_P0, 32'd262144);
            end
            1: begin
                write_reg(CFG_DEG, 32'd1);
                write_reg(CFG_A, 32'h7FFFFFFF);
                write_reg(CFG_B, 32'h80000000);
                write_reg(CFG_H, 32'h80000000);
                write_reg(CFG_Q, 32'h7FFFFFFF);
                write_reg(CFG_R, 32'd1);
                write_reg(CFG_P0, 32'hFFFFFFFF);
            end
            2: begin
                write_reg(CFG_DEG, 32'hFFFFFFFE);
                write_reg(CFG_A, 32'h80000000);
                write_reg(CFG_B, 32'h7FFFFFFF);
                write_reg(CFG_H, 32'd0);
                write_reg(CFG_Q, 32'h80000000);
                write_reg(CFG_R, 32'h7FFFFFFF);
                write_reg(CFG_P0, 32'd0);
            end
            3: begin
                write_reg(CFG_DEG, 32'd1);
                write_reg(CFG_A, 32'd64000 + $urandom_range(3000));
                write_reg(CFG_B, $urandom);
                write_reg(CFG_H, 32'd60000 + $urandom_range(10000));
                write_reg(CFG_Q, $urandom_range(20000));
                write_reg(CFG_R, 32'd1 + $urandom_range(1 << 20));
                write_reg(CFG_P0, $urandom);
            end
            default: begin
                r = $urandom;
                if (r[30:0] == 0) r[0] = 1'b1;
                write_reg(CFG_DEG, $urandom);
                write_reg(CFG_A, $urandom);
                write_reg(CFG_B, $urandom);
                write_reg(CFG_H, $urandom);
                write_reg(CFG_Q, $urandom);
                write_reg(CFG_R, r);
                write_reg(CFG_P0, $urandom);
            end
        endcase
        // unknown index must leave everything alone
        write_reg(CFG_UNUSED, $urandom);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (tilt_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    // result side: random stall, compare against the oldest expectation
    always @(posedge i_clk) begin
        t_tilt e;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (tilt_q.size() == 0) begin
                $display("%0t: unexpected transaction roll %0d pitch %0d", $time,
                         result_if.raw_roll, result_if.raw_pitch);
                failed = 1'b1;
            end else begin
                e = tilt_q.pop_front();
                if (result_if.raw_roll !== e.raw_roll) begin
                    $display("%0t: raw_roll exp %0d act %0d", $time, e.raw_roll,
                             result_if.raw_roll);
                    failed = 1'b1;
                end
                if (result_if.raw_pitch !== e.raw_pitch) begin
                    $display("%0t: raw_pitch exp %0d act %0d", $time, e.raw_pitch,
                             result_if.raw_pitch);
                    failed = 1'b1;
                end
                if (result_if.filtered_roll !== e.filt_roll) begin
                    $display("%0t: filtered_roll exp %0d act %0d", $time, e.filt_roll,
                             result_if.filtered_roll);
                    failed = 1'b1;
                end
                if (result_if.filtered_pitch !== e.filt_pitch) begin
                    $display("%0t: filtered_pitch exp %0d act %0d", $time, e.filt_pitch,
                             result_if.filtered_pitch);
                    failed = 1'b1;
                end
            end
        end
        if (!i_rst_n) result_if.ready <= 1'b0;
        else result_if.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    initial begin
        #40ms;
        $display("tilt_kalman_fusion_test failed");
        $finish;
    end

    initial begin
        t_row  rows[$];
        t_row  row;
        t_tilt zero_tilt;
        zero_tilt = '{0, 0, 0, 0};
        // directed table: all zeros first, straight after reset
        row.typed = 1'b1; row.tilt = zero_tilt;
        row.imu = '{0, 0, 0, 0, 0};                          rows.push_back(row);
        row.typed = 1'b0;
        row.imu = '{0, ONE_G, 0, 0, 0};                      rows.push_back(row);
        row.imu = '{0, -ONE_G, 0, 0, 0};                     rows.push_back(row);
        row.imu = '{ONE_G, 0, 0, 0, 0};                      rows.push_back(row);
        row.imu = '{-ONE_G, 0, 0, 0, 0};                     rows.push_back(row);
        row.imu = '{0, 0, ONE_G, 0, 0};                      rows.push_back(row);
        row.imu = '{0, 0, -ONE_G, 65536, -65536};            rows.push_back(row);
        row.imu = '{46341, 0, 46341, 0, 0};                  rows.push_back(row);
        row.imu = '{0, 46341, -46341, 0, 0};                 rows.push_back(row);
        row.imu = '{S_MAX, S_MAX, S_MAX, S_MAX, S_MAX};      rows.push_back(row);
        row.imu = '{S_MIN, S_MIN, S_MIN, S_MIN, S_MIN};      rows.push_back(row);
        row.imu = '{S_MIN, S_MAX, S_MIN, S_MAX, S_MIN};      rows.push_back(row);
        row.imu = '{0, S_MAX, 0, S_MIN, S_MAX};              rows.push_back(row);
        row.imu = '{S_MIN, 0, 0, 0, 0};                      rows.push_back(row);
        row.imu = '{0, 0, 0, S_MAX, S_MAX};                  rows.push_back(row);
        row.imu = '{0, 0, 0, S_MIN, S_MIN};                  rows.push_back(row);
        row.imu = '{1, -1, 1, 1, -1};                        rows.push_back(row);
        row.imu = '{-1, 0, 0, 0, 0};                         rows.push_back(row);
        row.imu = '{30000, -20000, 60000, 4000, -4000};      rows.push_back(row);

        restore_defaults();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_sample(rows[i].imu, rows[i].typed, rows[i].tilt);
        sample_if.valid <= 1'b0;
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            apply_setting(ph);
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 82; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 82; end
                default: begin tx_idle_pct = 19; rx_stall_pct = 19; end
            endcase
            repeat (106) send_sample(random_imu(), 1'b0, zero_tilt);
            sample_if.valid <= 1'b0;
            drain();
        end

        if (!failed) $display("tilt_kalman_fusion_test passed");
        else $display("tilt_kalman_fusion_test failed");
        $finish;
    end

endmodule

[files.f]
sv/tkf_pkg.sv
sv/tkf_if.sv
sv/tkf_ctrl.sv
sv/tkf_datapath.sv
sv/tilt_kalman_fusion.sv
sv/tkf_checker.sv
tb/tilt_kalman_fusion_test.sv
